FILE: rtl/jkv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jkv_pkg: shared types and constants of the JSON key/value extractor
// Holds the payload structs, the parser phase enum and register indexes.
// ----------------------------------------------------------------------------
package jkv_pkg;

    localparam int unsigned KeyCharsDefault    = 16;
    localparam int unsigned StringLimitDefault = 256;

    localparam logic [2:0] RegKeyLength   = 3'd0;
    localparam logic [2:0] RegKeyCharsLow = 3'd1;
    localparam logic [2:0] RegKeyCharsHi  = 3'd2;
    localparam logic [2:0] RegValueKind   = 3'd3;
    localparam logic [2:0] RegDefault     = 3'd4;
    localparam logic [2:0] RegCapacity    = 3'd5;

    localparam logic [2:0] KindPresence = 3'd0;
    localparam logic [2:0] KindBool     = 3'd1;
    localparam logic [2:0] KindSigned   = 3'd2;
    localparam logic [2:0] KindUnsigned = 3'd3;
    localparam logic [2:0] KindString   = 3'd4;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       doc_end;
    } t_in_item;

    typedef struct packed {
        logic signed [32:0] value;
        logic               is_final;
        logic               found;
    } t_out_item;

    // Front-end classification handed to the back end through the queue.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       key_hit;    // key pattern matched at this byte
        logic       take;       // byte goes to the value parser
        logic       finish;     // document ends with this byte
    } t_cls_item;

    typedef enum logic [3:0] {
        PH_SEARCH, PH_AFTER_KEY, PH_AFTER_COLON, PH_BOOL_WORD, PH_NUM_SIGN,
        PH_NUM_DIGITS, PH_STR_BODY, PH_DONE, PH_FAIL
    } t_phase;

endpackage
`default_nettype wire

FILE: rtl/jkv_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jkv_front: byte window and key matcher
// Shifts text bytes into a window and flags the closing quote of the key.
// ----------------------------------------------------------------------------
module jkv_front #(
    parameter int unsigned KEY_CHARS = jkv_pkg::KeyCharsDefault
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    input  wire jkv_pkg::t_in_item        i_item,
    input  wire logic [KEY_CHARS*8-1:0]   i_key,
    input  wire logic [5:0]               i_key_n,
    output jkv_pkg::t_cls_item            o_cls
);
    localparam int unsigned WinLen = KEY_CHARS + 2;

    logic [7:0] r_win [WinLen];
    logic [7:0] w_new [WinLen];
    logic       w_hit;

    // Window as it will look after this byte: newest at index 0.
    always_comb begin
        w_new[0] = i_item.text_byte;
        for (int i = 1; i < WinLen; i++) begin
            w_new[i] = r_win[i-1];
        end
    end

    // Pattern: w[0] quote, w[k] = key[n-k], w[n+1] quote.
    always_comb begin
        logic ok;
        ok = (i_key_n != '0) && (w_new[0] == 8'h22);
        for (int k = 1; k <= KEY_CHARS; k++) begin
            if (k <= int'(i_key_n)) begin
                if (w_new[k] != i_key[(int'(i_key_n) - k)*8 +: 8]) ok = 1'b0;
            end
        end
        for (int k = 1; k <= KEY_CHARS + 1; k++) begin
            if (k == int'(i_key_n) + 1 && w_new[k] != 8'h22) ok = 1'b0;
        end
        w_hit = ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WinLen; i++) r_win[i] <= '0;
        end else if (i_valid) begin
            if (i_item.text_byte == 8'h00 || i_item.doc_end) begin
                for (int i = 0; i < WinLen; i++) r_win[i] <= '0;
            end else begin
                for (int i = 0; i < WinLen; i++) r_win[i] <= w_new[i];
            end
        end
    end

    always_comb begin
        o_cls.text_byte = i_item.text_byte;
        o_cls.take      = (i_item.text_byte != 8'h00);
        o_cls.key_hit   = w_hit && (i_item.text_byte != 8'h00);
        o_cls.finish    = (i_item.text_byte == 8'h00) || i_item.doc_end;
    end
endmodule
`default_nettype wire

FILE: rtl/jkv_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jkv_queue: small register FIFO between front and back end
// Two entries, decoupling the classifier from the value parser.
// ----------------------------------------------------------------------------
module jkv_queue (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire jkv_pkg::t_cls_item  i_data,
    output logic                     o_full,
    input  wire logic                i_pop,
    output logic                     o_empty,
    output jkv_pkg::t_cls_item       o_data
);
    jkv_pkg::t_cls_item r_mem [2];
    logic               r_wp;
    logic               r_rp;
    logic [1:0]         r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) r_wp <= ~r_wp;
            if (i_pop && !o_empty) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push && !o_full) - 2'(i_pop && !o_empty);
        end
    end

`ifndef SYNTH
    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |=> !(r_cnt == 2'd3))
        else $error("queue count overflow");
`endif
endmodule
`default_nettype wire

FILE: rtl/jkv_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jkv_back: value parser and result queue
// Runs the value phase machine on classified bytes and queues results.
// ----------------------------------------------------------------------------
module jkv_back #(
    parameter int unsigned STRING_LIMIT = jkv_pkg::StringLimitDefault
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire jkv_pkg::t_cls_item  i_cls,
    input  wire logic [2:0]          i_kind,
    input  wire logic [32:0]         i_default,
    input  wire logic [8:0]          i_capacity,
    output logic                     o_empty,
    input  wire logic                i_pop,
    output jkv_pkg::t_out_item       o_item
);
    localparam int unsigned CapW = $clog2(STRING_LIMIT + 1);
    localparam logic [32:0] Clamp = 33'h1_0000_0000;

    // Saturate or wrap the accumulated magnitude into the answer for the kind.
    function automatic logic [32:0] num_final(logic [32:0] a, logic ng, logic [2:0] kind);
        logic [32:0] r;
        if (kind == jkv_pkg::KindUnsigned) begin
            if (a > 33'h0_FFFF_FFFF) r = 33'h0_FFFF_FFFF;
            else if (ng) r = {1'b0, 32'(Clamp - a)};
            else r = a;
        end else if (ng) begin
            r = 33'd0 - ((a > 33'h0_8000_0000) ? 33'h0_8000_0000 : a);
        end else begin
            r = (a > 33'h0_7FFF_FFFF) ? 33'h0_7FFF_FFFF : a;
        end
        return r;
    endfunction

    jkv_pkg::t_phase r_ph, n_ph;
    logic        r_esc, n_esc;
    logic [CapW-1:0] r_cnt, n_cnt;
    logic [32:0] r_acc, n_acc;
    logic        r_neg, n_neg;
    logic [2:0]  r_wp, n_wp;
    logic        r_done, n_done;

    // Result queue, four entries (two results per byte at most).
    jkv_pkg::t_out_item r_q [4];
    logic [1:0] r_qw, r_qr;
    logic [2:0] r_qn;
    jkv_pkg::t_out_item w_r0, w_r1;
    logic       w_e0, w_e1;
    logic       w_go;

    logic [CapW-1:0] w_cap;
    logic [7:0]  b;
    logic [7:0]  l;
    logic        blank4, digit;
    logic [3:0]  dval;
    logic [36:0] w_mul;
    logic [32:0] w_fin;
    logic [32:0] w_miss;
    logic [7:0]  w_chr;
    logic [7:0]  w_wch;
    logic [2:0]  w_wlen;

    assign w_cap = (32'(i_capacity) > 32'(STRING_LIMIT)) ? CapW'(STRING_LIMIT)
                                                          : CapW'(i_capacity);
    assign o_ready = (r_qn <= 3'd2);
    assign w_go    = i_valid && o_ready;
    assign b       = i_cls.text_byte;
    assign l       = b | 8'h20;
    assign blank4  = (b == 8'd32) || (b == 8'd9) || (b == 8'd10) || (b == 8'd13);
    assign digit   = (b >= 8'h30) && (b <= 8'h39);
    assign dval    = 4'(b - 8'h30);
    assign w_mul   = {r_acc, 3'b000} + {2'b00, r_acc, 1'b0} + 37'(dval);
    assign w_miss  = (i_kind >= jkv_pkg::KindBool && i_kind <= jkv_pkg::KindUnsigned)
                     ? i_default : 33'd0;
    assign w_fin   = num_final(r_acc, r_neg, i_kind);

    always_comb begin
        case (r_wp)
            3'd1:    w_wch = r_acc[0] ? 8'h72 : 8'h61;
            3'd2:    w_wch = r_acc[0] ? 8'h75 : 8'h6c;
            3'd3:    w_wch = r_acc[0] ? 8'h65 : 8'h73;
            3'd4:    w_wch = 8'h65;
            default: w_wch = 8'h00;
        endcase
    end
    assign w_wlen = r_acc[0] ? 3'd4 : 3'd5;
    assign w_chr  = (b == 8'h6e) ? 8'd10 : (b == 8'h72) ? 8'd13 :
                    (b == 8'h74) ? 8'd9 : b;

    always_comb begin
        logic [CapW-1:0] c1;
        n_ph = r_ph; n_esc = r_esc; n_cnt = r_cnt; n_acc = r_acc;
        n_neg = r_neg; n_wp = r_wp; n_done = r_done;
        w_e0 = 1'b0; w_e1 = 1'b0;
        w_r0 = '0; w_r1 = '0;
        c1 = r_cnt + 1'b1;
        if (i_cls.take && !r_done) begin
            case (r_ph)
                jkv_pkg::PH_SEARCH: begin
                    if (i_cls.key_hit) n_ph = jkv_pkg::PH_AFTER_KEY;
                end
                jkv_pkg::PH_AFTER_KEY: begin
                    if (!blank4) begin
                        n_done = 1'b1;
                        if (b != 8'h3a) begin
                            n_ph = jkv_pkg::PH_FAIL; n_acc = '0;
                        end else if (i_kind == jkv_pkg::KindPresence
                                     || i_kind > jkv_pkg::KindString) begin
                            n_ph = jkv_pkg::PH_DONE; n_acc = 33'd1;
                        end else if (i_kind == jkv_pkg::KindString && w_cap == '0) begin
                            n_ph = jkv_pkg::PH_FAIL; n_acc = '0;
                        end else begin
                            n_ph = jkv_pkg::PH_AFTER_COLON; n_done = 1'b0;
                        end
                    end
                end
                jkv_pkg::PH_AFTER_COLON: begin
                    if (!blank4) begin
                        if (i_kind == jkv_pkg::KindBool) begin
                            if (l == 8'h74 || l == 8'h66) begin
                                n_acc = {32'd0, l == 8'h74};
                                n_wp = 3'd1; n_ph = jkv_pkg::PH_BOOL_WORD;
                            end else begin
                                n_done = 1'b1;
                                if (b == 8'h31) begin
                                    n_ph = jkv_pkg::PH_DONE; n_acc = 33'd1;
                                end else if (b == 8'h30) begin
                                    n_ph = jkv_pkg::PH_DONE; n_acc = 33'd0;
                                end else begin
                                    n_ph = jkv_pkg::PH_FAIL; n_acc = 33'd0;
                                end
                            end
                        end else if (i_kind == jkv_pkg::KindSigned
                                     || i_kind == jkv_pkg::KindUnsigned) begin
                            if (b == 8'd11 || b == 8'd12) begin
                                n_ph = r_ph;
                            end else if (b == 8'h2b || b == 8'h2d) begin
                                n_neg = (b == 8'h2d); n_ph = jkv_pkg::PH_NUM_SIGN;
                            end else if (digit) begin
                                n_acc = 33'(dval); n_ph = jkv_pkg::PH_NUM_DIGITS;
                            end else begin
                                n_ph = jkv_pkg::PH_DONE; n_acc = '0; n_done = 1'b1;
                            end
                        end else if (i_kind == jkv_pkg::KindString) begin
                            if (b != 8'h22 || w_cap == '0) begin
                                n_ph = jkv_pkg::PH_FAIL; n_acc = '0; n_done = 1'b1;
                            end else if (w_cap == CapW'(1)) begin
                                n_ph = jkv_pkg::PH_DONE; n_acc = '0; n_done = 1'b1;
                            end else begin
                                n_ph = jkv_pkg::PH_STR_BODY;
                            end
                        end else begin
                            n_ph = jkv_pkg::PH_DONE; n_acc = 33'd1; n_done = 1'b1;
                        end
                    end
                end
                jkv_pkg::PH_BOOL_WORD: begin
                    if (r_wp >= w_wlen || l != w_wch) begin
                        n_ph = jkv_pkg::PH_FAIL; n_acc = '0; n_done = 1'b1;
                    end else begin
                        n_wp = r_wp + 3'd1;
                        if (n_wp == w_wlen) begin
                            n_ph = jkv_pkg::PH_DONE; n_done = 1'b1;
                        end
                    end
                end
                jkv_pkg::PH_NUM_SIGN: begin
                    if (digit) begin
                        n_acc = 33'(dval); n_ph = jkv_pkg::PH_NUM_DIGITS;
                    end else begin
                        n_ph = jkv_pkg::PH_DONE; n_acc = '0; n_done = 1'b1;
                    end
                end
                jkv_pkg::PH_NUM_DIGITS: begin
                    if (digit) begin
                        n_acc = (w_mul > 37'(Clamp)) ? Clamp : w_mul[32:0];
                    end else begin
                        n_ph = jkv_pkg::PH_DONE; n_acc = w_fin; n_done = 1'b1;
                    end
                end
                jkv_pkg::PH_STR_BODY: begin
                    if (w_cap < CapW'(2)) begin
                        n_ph = jkv_pkg::PH_DONE; n_acc = 33'(r_cnt); n_done = 1'b1;
                    end else if (r_esc || (b != 8'h5c && b != 8'h22)) begin
                        n_esc = 1'b0;
                        w_e0 = 1'b1;
                        w_r0.value = 33'(r_esc ? w_chr : b);
                        n_cnt = c1;
                        if (c1 >= w_cap - 1'b1) begin
                            n_ph = jkv_pkg::PH_DONE; n_acc = 33'(c1); n_done = 1'b1;
                        end
                    end else if (b == 8'h5c) begin
                        n_esc = 1'b1;
                    end else begin
                        n_ph = jkv_pkg::PH_DONE; n_acc = 33'(r_cnt); n_done = 1'b1;
                    end
                end
                default: n_ph = r_ph;
            endcase
        end
        if (i_cls.finish) begin
            w_e1 = 1'b1;
            w_r1.is_final = 1'b1;
            case (n_ph)
                jkv_pkg::PH_AFTER_COLON: begin
                    if (i_kind == jkv_pkg::KindSigned || i_kind == jkv_pkg::KindUnsigned) begin
                        w_r1.value = '0; w_r1.found = 1'b1;
                    end else if (i_kind == jkv_pkg::KindBool
                                 || i_kind == jkv_pkg::KindString) begin
                        w_r1.value = w_miss;
                    end else begin
                        w_r1.value = 33'd1; w_r1.found = 1'b1;
                    end
                end
                jkv_pkg::PH_NUM_SIGN, jkv_pkg::PH_NUM_DIGITS: begin
                    // final number uses the post-byte accumulator and sign
                    w_r1.found = 1'b1;
                    w_r1.value = num_final(n_acc, n_neg, i_kind);
                end
                jkv_pkg::PH_STR_BODY: begin
                    w_r1.value = 33'(n_cnt); w_r1.found = 1'b1;
                end
                jkv_pkg::PH_DONE: begin
                    w_r1.value = n_acc; w_r1.found = 1'b1;
                end
                default: w_r1.value = w_miss;
            endcase
            n_ph = jkv_pkg::PH_SEARCH; n_esc = 1'b0; n_cnt = '0; n_acc = '0;
            n_neg = 1'b0; n_wp = '0; n_done = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= jkv_pkg::PH_SEARCH; r_esc <= 1'b0; r_cnt <= '0; r_acc <= '0;
            r_neg <= 1'b0; r_wp <= '0; r_done <= 1'b0;
        end else if (w_go) begin
            r_ph <= n_ph; r_esc <= n_esc; r_cnt <= n_cnt; r_acc <= n_acc;
            r_neg <= n_neg; r_wp <= n_wp; r_done <= n_done;
        end
    end

    logic       w_p0, w_p1;
    logic       w_qpop;
    assign w_p0   = w_go && w_e0;
    assign w_p1   = w_go && w_e1;
    assign w_qpop = i_pop && !o_empty;
    assign o_empty = (r_qn == 3'd0);
    assign o_item  = r_q[r_qr];

    always_ff @(posedge i_clk) begin
        if (w_p0) r_q[r_qw] <= w_r0;
        if (w_p1) r_q[r_qw + 2'(w_p0)] <= w_r1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qw <= '0; r_qr <= '0; r_qn <= '0;
        end else begin
            r_qw <= r_qw + 2'(w_p0) + 2'(w_p1);
            r_qr <= r_qr + 2'(w_qpop);
            r_qn <= r_qn + 3'(w_p0) + 3'(w_p1) - 3'(w_qpop);
        end
    end

`ifndef SYNTH
    a_qn_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qn <= 3'd4)
        else $error("result queue overflow");
    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_p1 |=> (r_ph == jkv_pkg::PH_SEARCH && !r_done))
        else $error("state not cleared after closing result");
    a_char_no_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_p0 |-> (!w_r0.is_final && !w_r0.found))
        else $error("character result flagged final");
`endif
endmodule
`default_nettype wire

FILE: rtl/json_key_value_extractor_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// json_key_value_extractor_unit: JSON field extractor
// Finds a configured quoted key in a byte stream and decodes its value.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive i_item and raise push when full is low; one document
//   byte transfers per cycle. A zero byte or doc_end closes the document.
//   Output queue: while empty is low the oldest result is on o_item; raise
//   pop to take it. Each byte yields zero, one or two results: a decoded
//   string character and/or the closing result (is_final, found, value).
//   Configuration: write i_cfg_wr with i_cfg_idx and i_cfg_data while idle.
// Throughput and flow:
//   One byte per cycle sustained while the receiver keeps up. A byte is
//   classified by the window matcher in the cycle it transfers and is
//   registered in a two-entry queue; the value parser takes it when the
//   result queue has room and registers its results there for popping.
// Reset and stall:
//   Synchronous active-low reset clears the window, the parser and both
//   queues; registers return to their reset values. When the receiver
//   stalls, the four-entry result queue fills, the parser holds, the middle
//   queue fills and full rises.
// ----------------------------------------------------------------------------
module json_key_value_extractor_unit #(
    parameter int unsigned KEY_CHARS    = jkv_pkg::KeyCharsDefault,
    parameter int unsigned STRING_LIMIT = jkv_pkg::StringLimitDefault
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire jkv_pkg::t_in_item  i_item,
    output logic                    empty,
    input  wire logic               pop,
    output jkv_pkg::t_out_item      o_item,
    input  wire logic               i_cfg_wr,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [63:0]        i_cfg_data
);
    logic [4:0]  r_key_len;
    logic [63:0] r_key_lo, r_key_hi;
    logic [2:0]  r_kind;
    logic [32:0] r_default;
    logic [8:0]  r_cap;

    logic [KEY_CHARS*8-1:0] w_key;
    logic [5:0]             w_key_n;
    jkv_pkg::t_cls_item     w_cls, w_qd;
    logic                   w_qfull, w_qempty, w_bready;

    // Register file: hold until written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_len <= '0; r_key_lo <= '0; r_key_hi <= '0;
            r_kind <= '0; r_default <= '0; r_cap <= 9'd256;
        end else if (i_cfg_wr) begin
            case (i_cfg_idx)
                jkv_pkg::RegKeyLength:   r_key_len <= i_cfg_data[4:0];
                jkv_pkg::RegKeyCharsLow: r_key_lo  <= i_cfg_data;
                jkv_pkg::RegKeyCharsHi:  r_key_hi  <= i_cfg_data;
                jkv_pkg::RegValueKind:   r_kind    <= i_cfg_data[2:0];
                jkv_pkg::RegDefault:     r_default <= i_cfg_data[32:0];
                jkv_pkg::RegCapacity:    r_cap     <= i_cfg_data[8:0];
                default:                 r_kind    <= r_kind;
            endcase
        end
    end

    // Effective key: chars up to the first zero byte; too long means never.
    always_comb begin
        logic [127:0] all;
        logic         stop;
        all = {r_key_hi, r_key_lo};
        w_key = '0;
        w_key_n = '0;
        stop = (int'(r_key_len) > KEY_CHARS);
        for (int i = 0; i < KEY_CHARS; i++) begin
            if (i < 16) w_key[i*8 +: 8] = all[i*8 +: 8];
            if (!stop && i < int'(r_key_len)) begin
                if (i >= 16 || all[(i%16)*8 +: 8] == 8'h00) stop = 1'b1;
                else w_key_n = w_key_n + 6'd1;
            end
        end
    end

    assign full = w_qfull;

    jkv_front #(.KEY_CHARS(KEY_CHARS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(push && !w_qfull), .i_item(i_item),
        .i_key(w_key), .i_key_n(w_key_n), .o_cls(w_cls)
    );

    jkv_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_data(w_cls), .o_full(w_qfull),
        .i_pop(w_bready), .o_empty(w_qempty), .o_data(w_qd)
    );

    jkv_back #(.STRING_LIMIT(STRING_LIMIT)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(!w_qempty), .o_ready(w_bready), .i_cls(w_qd),
        .i_kind(r_kind), .i_default(r_default), .i_capacity(r_cap),
        .o_empty(empty), .i_pop(pop), .o_item(o_item)
    );

`ifndef SYNTH
    a_cap_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_cap == 9'd256 && r_key_len == '0))
        else $error("config registers not reset");
    a_key_len_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(w_key_n) <= KEY_CHARS)
        else $error("effective key too long");
    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (full && !w_bready) |=> full)
        else $error("input queue drained without back end");
`endif
endmodule
`default_nettype wire
